// ===== hdl/edlb_pkg.sv =====
// ----------------------------------------------------------------------------
// edlb_pkg
// Shared types, constants and helpers for the echo distance LED bar core.
// ----------------------------------------------------------------------------
package edlb_pkg;

    // field widths
    localparam int TIME_W     = 32;
    localparam int WIDTH_W    = 16;
    localparam int INTERVAL_W = 8;
    localparam int BLINK_W    = 16;
    localparam int LED_W      = 5;
    localparam int CM_W       = 11;
    localparam int IDX_W      = 3;
    localparam int CFG_DATA_W = 16;

    // stream packing widths
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_READ_INTERVAL = 3'd0;
    localparam logic [IDX_W-1:0] REG_FAR_BLINK     = 3'd1;
    localparam logic [IDX_W-1:0] REG_OUTER_BLINK   = 3'd2;
    localparam logic [IDX_W-1:0] REG_MIDDLE_BLINK  = 3'd3;
    localparam logic [IDX_W-1:0] REG_NEAR_BLINK    = 3'd4;
    localparam logic [IDX_W-1:0] REG_CLOSE_BLINK   = 3'd5;

    // configuration reset values
    localparam logic [INTERVAL_W-1:0] RST_READ_INTERVAL = 8'd50;
    localparam logic [BLINK_W-1:0]    RST_FAR_BLINK     = 16'd1000;
    localparam logic [BLINK_W-1:0]    RST_OUTER_BLINK   = 16'd800;
    localparam logic [BLINK_W-1:0]    RST_MIDDLE_BLINK  = 16'd500;
    localparam logic [BLINK_W-1:0]    RST_NEAR_BLINK    = 16'd300;
    localparam logic [BLINK_W-1:0]    RST_CLOSE_BLINK   = 16'd70;

    // cm = floor(width * 10 / 582) = floor(width * 5 / 291), exact for 16-bit
    // widths as (width * ceil(5 * 2^25 / 291)) >> 25
    localparam int               RECIP_W    = 20;
    localparam int               DIST_SHIFT = 25;
    localparam int               PROD_W     = WIDTH_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIST_RECIP = 20'd576537;

    // distance limits and zone thresholds in cm
    localparam logic [CM_W-1:0] MIN_CM     = 11'd1;
    localparam logic [CM_W-1:0] MAX_CM     = 11'd400;
    localparam logic [CM_W-1:0] MAX_OUT_CM = 11'd1126;
    localparam logic [CM_W-1:0] FAR_CM     = 11'd300;
    localparam logic [CM_W-1:0] OUTER_CM   = 11'd250;
    localparam logic [CM_W-1:0] MIDDLE_CM  = 11'd100;
    localparam logic [CM_W-1:0] NEAR_CM    = 11'd30;

    // distance zones, one per LED
    typedef enum logic [2:0] {
        ZONE_FAR,
        ZONE_OUTER,
        ZONE_MIDDLE,
        ZONE_NEAR,
        ZONE_CLOSE
    } zone_t;

    // configuration register set
    typedef struct packed {
        logic [INTERVAL_W-1:0] read_interval_ms;
        logic [BLINK_W-1:0]    far_blink_ms;
        logic [BLINK_W-1:0]    outer_blink_ms;
        logic [BLINK_W-1:0]    middle_blink_ms;
        logic [BLINK_W-1:0]    near_blink_ms;
        logic [BLINK_W-1:0]    close_blink_ms;
    } cfg_t;

    // distance and zone of one echo
    typedef struct packed {
        logic [CM_W-1:0] cm;
        logic            in_range;
        zone_t           zone;
    } dist_info_t;

    // LEDs that are always lit below the zone's own LED
    function automatic logic [LED_W-1:0] zone_below(zone_t z);
        logic [LED_W-1:0] pat;
        case (z)
            ZONE_FAR:    pat = 5'b00000;
            ZONE_OUTER:  pat = 5'b00001;
            ZONE_MIDDLE: pat = 5'b00011;
            ZONE_NEAR:   pat = 5'b00111;
            ZONE_CLOSE:  pat = 5'b01111;
            default:     pat = 5'b00000;
        endcase
        return pat;
    endfunction

    // the zone's own blinking LED
    function automatic logic [LED_W-1:0] zone_led(zone_t z);
        logic [LED_W-1:0] pat;
        case (z)
            ZONE_FAR:    pat = 5'b00001;
            ZONE_OUTER:  pat = 5'b00010;
            ZONE_MIDDLE: pat = 5'b00100;
            ZONE_NEAR:   pat = 5'b01000;
            ZONE_CLOSE:  pat = 5'b10000;
            default:     pat = 5'b00000;
        endcase
        return pat;
    endfunction

endpackage

// ===== hdl/edlb_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// edlb_cfg_regs
// Configuration register set: read interval and the five zone blink periods.
// ----------------------------------------------------------------------------
module edlb_cfg_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [edlb_pkg::IDX_W-1:0]           cfg_index,
    input  logic [edlb_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output edlb_pkg::cfg_t                       cfg
);
    import edlb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode the write, indexes beyond the list are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_READ_INTERVAL: cfg_next.read_interval_ms = cfg_wdata[INTERVAL_W-1:0];
                REG_FAR_BLINK:     cfg_next.far_blink_ms     = cfg_wdata[BLINK_W-1:0];
                REG_OUTER_BLINK:   cfg_next.outer_blink_ms   = cfg_wdata[BLINK_W-1:0];
                REG_MIDDLE_BLINK:  cfg_next.middle_blink_ms  = cfg_wdata[BLINK_W-1:0];
                REG_NEAR_BLINK:    cfg_next.near_blink_ms    = cfg_wdata[BLINK_W-1:0];
                REG_CLOSE_BLINK:   cfg_next.close_blink_ms   = cfg_wdata[BLINK_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // register set with reset defaults
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.read_interval_ms <= RST_READ_INTERVAL;
            cfg_reg.far_blink_ms     <= RST_FAR_BLINK;
            cfg_reg.outer_blink_ms   <= RST_OUTER_BLINK;
            cfg_reg.middle_blink_ms  <= RST_MIDDLE_BLINK;
            cfg_reg.near_blink_ms    <= RST_NEAR_BLINK;
            cfg_reg.close_blink_ms   <= RST_CLOSE_BLINK;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/edlb_dist_calc.sv =====
// ----------------------------------------------------------------------------
// edlb_dist_calc
// Echo width to centimetres by reciprocal multiply, range check and zone.
// ----------------------------------------------------------------------------
module edlb_dist_calc (
    input  logic [edlb_pkg::WIDTH_W-1:0] echo_width_us,
    output edlb_pkg::dist_info_t         dist_info
);
    import edlb_pkg::*;

    logic [PROD_W-1:0] prod;
    logic [CM_W-1:0]   cm;

    // width * 5 / 291 as a fixed-point multiply and shift
    assign prod = {{RECIP_W{1'b0}}, echo_width_us} * {{WIDTH_W{1'b0}}, DIST_RECIP};
    assign cm   = prod[DIST_SHIFT +: CM_W];

    // range check and zone select
    always_comb begin
        dist_info.cm       = cm;
        dist_info.in_range = (cm >= MIN_CM) && (cm <= MAX_CM);
        if (cm >= FAR_CM) begin
            dist_info.zone = ZONE_FAR;
        end else if (cm >= OUTER_CM) begin
            dist_info.zone = ZONE_OUTER;
        end else if (cm >= MIDDLE_CM) begin
            dist_info.zone = ZONE_MIDDLE;
        end else if (cm >= NEAR_CM) begin
            dist_info.zone = ZONE_NEAR;
        end else begin
            dist_info.zone = ZONE_CLOSE;
        end
    end

endmodule

// ===== hdl/echo_distance_led_bar_core.sv =====
// ----------------------------------------------------------------------------
// echo_distance_led_bar_core
// Trigger pacing, echo distance and blinking five-LED zone bar.
// ----------------------------------------------------------------------------
//  channel  | ports                          | contents
//  ---------+--------------------------------+-------------------------------
//  input    | s_tvalid s_tready s_tdata s_tuser | time, echo width, echo flag
//  result   | m_tvalid m_tready m_tdata m_tuser | trigger, leds, cm, cm flag
//  config   | cfg_we cfg_index cfg_wdata      | six registers, write only
//
//  one item per cycle sustained while m_tready keeps the result moving; an item
//  is held in the input register and then passes into the result register
//  timing, blink and LED state update as the item leaves the input register
//  reset is synchronous; both stages empty, state and registers at defaults
//  a stalled result holds; the input register keeps taking items while the
//  result register drains, and stalls only when both are full
// ----------------------------------------------------------------------------
module echo_distance_led_bar_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input items
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [edlb_pkg::S_TDATA_W-1:0]        s_tdata,   // now_ms, echo_width_us
    input  logic [0:0]                            s_tuser,   // echo_ready
    // result items
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [edlb_pkg::M_TDATA_W-1:0]        m_tdata,   // trigger, leds, distance_cm, pad
    output logic [0:0]                            m_tuser,   // distance_valid
    // configuration writes
    input  logic                                  cfg_we,
    input  logic [edlb_pkg::IDX_W-1:0]            cfg_index,
    input  logic [edlb_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import edlb_pkg::*;

    cfg_t       cfg;
    dist_info_t dist_info;

    // input register
    logic               in_valid_reg, in_valid_next;
    logic [TIME_W-1:0]  now_reg;
    logic               ready_reg;
    logic [WIDTH_W-1:0] width_reg;

    // block state
    logic [TIME_W-1:0] last_trig_reg, last_trig_next;
    logic [TIME_W-1:0] last_blink_reg, last_blink_next;
    logic [LED_W-1:0]  leds_reg, leds_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic              trig_out_reg;
    logic [LED_W-1:0]  leds_out_reg;
    logic [CM_W-1:0]   cm_out_reg;
    logic              dv_out_reg;

    logic              advance;
    logic              trig;
    logic [TIME_W-1:0] trig_elapsed;
    logic [TIME_W-1:0] blink_elapsed;
    logic [BLINK_W-1:0] blink_period;
    logic              blink_due;
    logic              led_update;

    edlb_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    edlb_dist_calc u_dist (
        .echo_width_us (width_reg),
        .dist_info     (dist_info)
    );

    // handshake between the two stages
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = s_tready ? s_tvalid : in_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // trigger pacing, elapsed time modulo 2^32
    assign trig_elapsed = now_reg - last_trig_reg;
    assign trig         = trig_elapsed >= {{(TIME_W-INTERVAL_W){1'b0}}, cfg.read_interval_ms};

    // blink period of the selected zone
    always_comb begin
        case (dist_info.zone)
            ZONE_FAR:    blink_period = cfg.far_blink_ms;
            ZONE_OUTER:  blink_period = cfg.outer_blink_ms;
            ZONE_MIDDLE: blink_period = cfg.middle_blink_ms;
            ZONE_NEAR:   blink_period = cfg.near_blink_ms;
            ZONE_CLOSE:  blink_period = cfg.close_blink_ms;
            default:     blink_period = cfg.close_blink_ms;
        endcase
    end

    assign blink_elapsed = now_reg - last_blink_reg;
    assign blink_due     = blink_elapsed >= {{(TIME_W-BLINK_W){1'b0}}, blink_period};
    assign led_update    = ready_reg && dist_info.in_range;

    // next state for timing and LEDs
    always_comb begin
        last_trig_next  = last_trig_reg;
        last_blink_next = last_blink_reg;
        leds_next       = leds_reg;
        if (advance) begin
            if (trig) begin
                last_trig_next = now_reg;
            end
            if (led_update) begin
                if (blink_due) begin
                    leds_next       = zone_below(dist_info.zone);
                    last_blink_next = now_reg;
                end else begin
                    leds_next = zone_below(dist_info.zone) | zone_led(dist_info.zone);
                end
            end
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_trig_reg  <= '0;
            last_blink_reg <= '0;
            leds_reg       <= '0;
        end else begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            last_trig_reg  <= last_trig_next;
            last_blink_reg <= last_blink_next;
            leds_reg       <= leds_next;
        end
    end

    // input payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            now_reg   <= s_tdata[TIME_W-1:0];
            width_reg <= s_tdata[TIME_W +: WIDTH_W];
            ready_reg <= s_tuser[0];
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            trig_out_reg <= trig;
            leds_out_reg <= leds_next;
            cm_out_reg   <= ready_reg ? dist_info.cm : '0;
            dv_out_reg   <= ready_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-1-LED_W-CM_W){1'b0}}, cm_out_reg, leds_out_reg, trig_out_reg};
    assign m_tuser  = dv_out_reg;

    // LED bar always shows a solid run from LED 0 upward
    a_leds_thermo: assert property (@(posedge aclk) disable iff (!aresetn)
        (leds_reg & (leds_reg + 5'd1)) == 5'd0)
        else $error("LED levels not a contiguous bar");

    // no echo means no distance in the result
    a_cm_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[LED_W+1 +: CM_W] == '0))
        else $error("distance without echo");

    // distance never beyond what a saturated width gives
    a_cm_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[LED_W+1 +: CM_W] <= MAX_OUT_CM))
        else $error("distance out of bounds");

    // an empty result register never blocks the input
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

    // items without an in-range echo leave the LEDs alone
    a_leds_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !led_update) |=> (leds_reg == $past(leds_reg)))
        else $error("LEDs changed without an in-range echo");

endmodule
